// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the page table walker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  `ASSERT_ALWAYS(label, (ante) |-> (cons), msg)

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  `ASSERT_ALWAYS(label, (ante) |=> (cons), msg)

`endif

// ----- rtl/rpw_pkg.sv -----
// Package with constants, types and the microcode table of the page table walker.
package rpw_pkg;

  localparam int POOL_FRAMES_DEF = 64;
  localparam int LEVELS_DEF      = 4;
  localparam int INDEX_BITS_DEF  = 9;
  localparam int VFN_WIDTH_DEF   = 36;

  localparam int HOST_W    = 52;
  localparam int LIMIT_W   = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [HOST_W-1:0]    BASE_FRAME_RST  = HOST_W'(256);
  localparam logic [LIMIT_W-1:0]   FRAME_LIMIT_RST = LIMIT_W'(64);

  localparam logic [CFG_IDX_W-1:0] REG_BASE_FRAME  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LIMIT = 1'b1;

  typedef logic [2:0] step_t;

  localparam step_t S_CLEAR = 3'd0;
  localparam step_t S_IDLE  = 3'd1;
  localparam step_t S_READ  = 3'd2;
  localparam step_t S_EVAL  = 3'd3;
  localparam step_t S_EMIT  = 3'd4;

  typedef enum logic [1:0] {
    HOLD_NONE = 2'd0,
    HOLD_CLR  = 2'd1,
    HOLD_IN   = 2'd2,
    HOLD_OUT  = 2'd3
  } hold_e;

  typedef enum logic [1:0] {
    JMP_NEVER  = 2'd0,
    JMP_ALWAYS = 2'd1,
    JMP_WALK   = 2'd2
  } jump_e;

  typedef struct packed {
    logic  act_clear;
    logic  act_accept;
    logic  act_read;
    logic  act_eval;
    logic  act_emit;
    hold_e hold_on;
    jump_e jump_on;
    step_t target;
  } ucode_t;

  typedef struct packed {
    logic clear;
    logic idle;
    logic accept;
    logic read;
    logic eval;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic clr_last;
    logic walk_on;
  } dp_status_t;

  typedef struct packed {
    logic [HOST_W-1:0] host_frame;
    logic              fault;
    logic              newly_mapped;
  } result_t;

  // Control store. A step holds while its hold condition is true, then jumps
  // to target when its jump condition is true and falls through otherwise.
  function automatic ucode_t ucode_rom(step_t pc);
    ucode_t w;
    w = '{act_clear: 1'b0, act_accept: 1'b0, act_read: 1'b0, act_eval: 1'b0,
          act_emit: 1'b0, hold_on: HOLD_NONE, jump_on: JMP_NEVER, target: S_IDLE};
    case (pc)
      S_CLEAR: begin
        w.act_clear = 1'b1;
        w.hold_on   = HOLD_CLR;
      end
      S_IDLE: begin
        w.act_accept = 1'b1;
        w.hold_on    = HOLD_IN;
      end
      S_READ: begin
        w.act_read = 1'b1;
      end
      S_EVAL: begin
        w.act_eval = 1'b1;
        w.jump_on  = JMP_WALK;
        w.target   = S_READ;
      end
      S_EMIT: begin
        w.act_emit = 1'b1;
        w.hold_on  = HOLD_OUT;
        w.jump_on  = JMP_ALWAYS;
        w.target   = S_IDLE;
      end
      default: begin
        w.jump_on = JMP_ALWAYS;
        w.target  = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/radix_page_table_walk_allocate.sv -----
// Top level of the four-level radix page table walker with on-demand allocation.
//
//   Channel   Handshake                    Payload
//   input     in_valid_i / in_stall_o      virt_frame_i
//   output    out_valid_o / out_stall_i    host_frame_o, fault_o, newly_mapped_o
//   config    cfg_we_i                     cfg_idx_i, cfg_data_i
//
// After reset a clearing pass zeroes all POOL_FRAMES * 2**INDEX_BITS entries
// of the table store (32768 by default), one entry a cycle; no word is taken then.
// A translation takes the word in the idle step, visits each level and ends in the
// emit step: all four levels for a full walk, fewer when the pool runs out early.
// Each level costs one read of the single-port table store and one evaluate step that
// checks the entry and writes back a freshly allocated frame.
// The result sits in an output register; a stalled output holds the walker in
// its final step until the word is taken, and the input is stalled meanwhile.
`include "assert_macros.svh"

module radix_page_table_walk_allocate
  import rpw_pkg::*;
#(
  parameter int POOL_FRAMES = POOL_FRAMES_DEF,
  parameter int LEVELS      = LEVELS_DEF,
  parameter int INDEX_BITS  = INDEX_BITS_DEF,
  parameter int VFN_WIDTH   = VFN_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration writes.
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [HOST_W-1:0]    cfg_data_i,
  // Incoming virtual frame numbers.
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [VFN_WIDTH-1:0] virt_frame_i,
  // Outgoing translations.
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [HOST_W-1:0]    host_frame_o,
  output logic                 fault_o,
  output logic                 newly_mapped_o
);

  ctrl_t      ctrl;
  dp_status_t dp_stat;
  result_t    res;
  logic       out_busy;

  logic              out_valid_q;
  logic [HOST_W-1:0] host_q;
  logic              fault_q;
  logic              newly_q;

  // The output register cannot take a new word while it holds one that is stalled.
  assign out_busy = out_valid_q & out_stall_i;

  rpw_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (dp_stat),
    .in_valid_i (in_valid_i),
    .out_busy_i (out_busy),
    .ctrl_o     (ctrl)
  );

  rpw_dp #(
    .POOL_FRAMES (POOL_FRAMES),
    .LEVELS      (LEVELS),
    .INDEX_BITS  (INDEX_BITS),
    .VFN_WIDTH   (VFN_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .virt_frame_i (virt_frame_i),
    .stat_o       (dp_stat),
    .res_o        (res)
  );

  // Input is open only in the idle step of the program.
  assign in_stall_o = !ctrl.idle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      host_q  <= res.host_frame;
      fault_q <= res.fault;
      newly_q <= res.newly_mapped;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign host_frame_o   = host_q;
  assign fault_o        = fault_q;
  assign newly_mapped_o = newly_q;

  `ASSERT_IMPLIES(a_fault_word_clean, out_valid_o && fault_o, host_frame_o == '0 && !newly_mapped_o, "fault word carries a frame")

endmodule

// ----- rtl/rpw_store.sv -----
// Single-port table store with registered read data.
module rpw_store #(
  parameter int ADDR_W = 15,
  parameter int DATA_W = 6,
  parameter int DEPTH  = 32768
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/rpw_seq.sv -----
// Microcoded sequencer: step counter, control store fetch and branch logic.
`include "assert_macros.svh"

module rpw_seq
  import rpw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_status_t stat_i,
  input  logic       in_valid_i,
  input  logic       out_busy_i,
  output ctrl_t      ctrl_o
);

  step_t  pc_q, pc_d;
  ucode_t word;
  logic   hold;
  logic   take;

  assign word = ucode_rom(pc_q);

  always_comb begin
    case (word.hold_on)
      HOLD_NONE: hold = 1'b0;
      HOLD_CLR:  hold = !stat_i.clr_last;
      HOLD_IN:   hold = !in_valid_i;
      HOLD_OUT:  hold = out_busy_i;
      default:   hold = 1'b0;
    endcase
    case (word.jump_on)
      JMP_NEVER:  take = 1'b0;
      JMP_ALWAYS: take = 1'b1;
      JMP_WALK:   take = stat_i.walk_on;
      default:    take = 1'b0;
    endcase
    if (hold) begin
      pc_d = pc_q;
    end else if (take) begin
      pc_d = word.target;
    end else begin
      pc_d = pc_q + step_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_CLEAR;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o.clear  = word.act_clear;
  assign ctrl_o.idle   = word.act_accept;
  assign ctrl_o.accept = word.act_accept & in_valid_i;
  assign ctrl_o.read   = word.act_read;
  assign ctrl_o.eval   = word.act_eval;
  assign ctrl_o.emit   = word.act_emit & !out_busy_i;

  `ASSERT_NEXT(a_read_then_eval, ctrl_o.read, ctrl_o.eval, "table read not followed by evaluation")

endmodule

// ----- rtl/rpw_dp.sv -----
// Walk datapath: configuration, index path, allocator, table store and result.
`include "assert_macros.svh"

module rpw_dp
  import rpw_pkg::*;
#(
  parameter int POOL_FRAMES = POOL_FRAMES_DEF,
  parameter int LEVELS      = LEVELS_DEF,
  parameter int INDEX_BITS  = INDEX_BITS_DEF,
  parameter int VFN_WIDTH   = VFN_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctrl_t                ctrl_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [HOST_W-1:0]    cfg_data_i,
  input  logic [VFN_WIDTH-1:0] virt_frame_i,
  output dp_status_t           stat_o,
  output result_t              res_o
);

  localparam int ENTRY_W = (POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1;
  localparam int ADDR_W  = ENTRY_W + INDEX_BITS;
  localparam int DEPTH   = POOL_FRAMES * (2 ** INDEX_BITS);
  localparam int NF_W    = $clog2(POOL_FRAMES + 1);
  localparam int CMP_W   = (NF_W > LIMIT_W) ? NF_W : LIMIT_W;
  localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int WALK_W  = LEVELS * INDEX_BITS;

  logic [HOST_W-1:0]  base_q;
  logic [LIMIT_W-1:0] limit_q;

  logic [WALK_W-1:0]  path_q, path_d;
  logic [ENTRY_W-1:0] table_q, table_d;
  logic [LVL_W-1:0]   level_q, level_d;
  logic [NF_W-1:0]    nf_q, nf_d;
  logic [ADDR_W-1:0]  clr_q;
  result_t            res_q, res_d;

  logic [VFN_WIDTH+WALK_W-1:0] vfn_ext;
  logic [INDEX_BITS-1:0]       idx;
  logic [ADDR_W-1:0]           walk_addr;
  logic [CMP_W-1:0]            limit_eff;
  logic                        alloc_ok;
  logic                        leaf;
  logic                        entry_zero;
  logic [ENTRY_W-1:0]          fresh;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_addr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ENTRY_W-1:0] mem_rdata;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= BASE_FRAME_RST;
      limit_q <= FRAME_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BASE_FRAME:  base_q  <= cfg_data_i;
        REG_FRAME_LIMIT: limit_q <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Index bits are aligned to the top of the frame number; missing low bits are zero.
  assign vfn_ext   = {virt_frame_i, {WALK_W{1'b0}}};
  assign idx       = path_q[WALK_W-1 -: INDEX_BITS];
  assign walk_addr = {table_q, idx};

  assign limit_eff  = (CMP_W'(limit_q) > CMP_W'(POOL_FRAMES)) ? CMP_W'(POOL_FRAMES)
                                                               : CMP_W'(limit_q);
  assign alloc_ok   = CMP_W'(nf_q) < limit_eff;
  assign leaf       = level_q == LVL_W'(LEVELS - 1);
  assign entry_zero = mem_rdata == '0;
  assign fresh      = nf_q[ENTRY_W-1:0];

  assign mem_we    = ctrl_i.clear | (ctrl_i.eval & entry_zero & alloc_ok);
  assign mem_addr  = ctrl_i.clear ? clr_q : walk_addr;
  assign mem_wdata = ctrl_i.clear ? '0 : fresh;

  rpw_store #(
    .ADDR_W (ADDR_W),
    .DATA_W (ENTRY_W),
    .DEPTH  (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (ctrl_i.read),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign stat_o.clr_last = clr_q == ADDR_W'(DEPTH - 1);
  assign stat_o.walk_on  = !leaf & (!entry_zero | alloc_ok);

  always_comb begin
    path_d  = path_q;
    table_d = table_q;
    level_d = level_q;
    nf_d    = nf_q;
    res_d   = res_q;
    if (ctrl_i.accept) begin
      path_d  = vfn_ext[VFN_WIDTH+WALK_W-1 -: WALK_W];
      table_d = '0;
      level_d = '0;
    end else if (ctrl_i.eval) begin
      if (!entry_zero) begin
        if (leaf) begin
          res_d.host_frame   = base_q + HOST_W'(mem_rdata);
          res_d.fault        = 1'b0;
          res_d.newly_mapped = 1'b0;
        end else begin
          table_d = mem_rdata;
        end
      end else if (!alloc_ok) begin
        res_d.host_frame   = '0;
        res_d.fault        = 1'b1;
        res_d.newly_mapped = 1'b0;
      end else begin
        nf_d = nf_q + NF_W'(1);
        if (leaf) begin
          res_d.host_frame   = base_q + HOST_W'(fresh);
          res_d.fault        = 1'b0;
          res_d.newly_mapped = 1'b1;
        end else begin
          table_d = fresh;
        end
      end
      if (stat_o.walk_on) begin
        level_d = level_q + LVL_W'(1);
        path_d  = path_q << INDEX_BITS;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nf_q    <= NF_W'(1);
      clr_q   <= '0;
      level_q <= '0;
    end else begin
      nf_q    <= nf_d;
      level_q <= level_d;
      if (ctrl_i.clear && !stat_o.clr_last) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    path_q  <= path_d;
    table_q <= table_d;
    res_q   <= res_d;
  end

  assign res_o = res_q;

  `ASSERT_IMPLIES(a_entry_allocated, ctrl_i.eval && !entry_zero, NF_W'(mem_rdata) < nf_q, "table entry points past the allocator")
  `ASSERT_ALWAYS(a_nf_in_pool, nf_q <= NF_W'(POOL_FRAMES), "allocator ran past the pool")

endmodule
